// ===== rtl/core/dlp_pkg.sv =====
package dlp_pkg;

  // Field widths.
  localparam int unsigned CapWidth   = 7;
  localparam int unsigned NameWidth  = 6;
  localparam int unsigned CountWidth = 60;
  localparam int unsigned HashWidth  = 64;

  // Line format limits.
  localparam logic [4:0] HASH_BYTES       = 5'd16;
  localparam logic [4:0] HASH_HALF        = 5'(HASH_BYTES / 2);
  localparam logic [4:0] MAX_COUNT_DIGITS = 5'd18;
  localparam logic [6:0] NAME_MAX_BYTES   = 7'd63;
  localparam logic [6:0] CAP_RESET        = 7'd40;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Line phase codes.
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_NAME  = 3'd1;
  localparam logic [2:0] PH_COUNT = 3'd2;
  localparam logic [2:0] PH_HASH  = 3'd3;
  localparam logic [2:0] PH_SKIP  = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_ROW  = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  // One result item.
  typedef struct packed {
    logic [1:0]            kind;
    logic [7:0]            name_char;
    logic [NameWidth-1:0]  name_length;
    logic [CountWidth-1:0] row_count;
    logic [HashWidth-1:0]  hash_high;
    logic [HashWidth-1:0]  hash_low;
  } res_t;

endpackage

// ===== rtl/core/dlp_in_reg.sv =====
module dlp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       ready_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // The held byte blocks a new request only when it cannot move on.
  assign in_stall_o = valid_q && !ready_i;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/core/dlp_parser.sv =====
module dlp_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dlp_pkg::CapWidth-1:0]  cfg_wdata_i,
  input  logic                          advance_i,
  input  logic [7:0]                    byte_i,
  output logic                          res_valid_o,
  output dlp_pkg::res_t                 res_o
);

  logic [dlp_pkg::CapWidth-1:0]   name_cap_q;
  logic [2:0]                     phase_q, phase_d;
  logic [dlp_pkg::NameWidth-1:0]  name_seen_q, name_seen_d;
  logic [dlp_pkg::CountWidth-1:0] count_acc_q, count_acc_d;
  logic [4:0]                     digits_seen_q, digits_seen_d;
  logic [dlp_pkg::HashWidth-1:0]  hash_hi_q, hash_hi_d;
  logic [dlp_pkg::HashWidth-1:0]  hash_lo_q, hash_lo_d;
  logic [4:0]                     hash_seen_q, hash_seen_d;

  logic [dlp_pkg::CapWidth-1:0]   cap_m1;
  logic [dlp_pkg::CapWidth-1:0]   limit;
  logic [3:0]                     digit;
  logic                           bad;
  logic                           clear;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_cap_q <= dlp_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      name_cap_q <= cfg_wdata_i;
    end
  end

  // Name length limit: capacity minus one, clamped to the name_length range.
  assign cap_m1 = (name_cap_q == '0) ? '0 : name_cap_q - 7'd1;
  assign limit  = (cap_m1 > dlp_pkg::NAME_MAX_BYTES) ? dlp_pkg::NAME_MAX_BYTES : cap_m1;
  assign digit  = 4'(byte_i - dlp_pkg::CH_ZERO);

  // Per-byte line parse.
  always_comb begin
    phase_d       = phase_q;
    name_seen_d   = name_seen_q;
    count_acc_d   = count_acc_q;
    digits_seen_d = digits_seen_q;
    hash_hi_d     = hash_hi_q;
    hash_lo_d     = hash_lo_q;
    hash_seen_d   = hash_seen_q;
    res_valid_o   = 1'b0;
    res_o         = '0;
    bad           = 1'b0;
    clear         = 1'b0;

    case (phase_q)
      dlp_pkg::PH_START, dlp_pkg::PH_NAME: begin
        if (byte_i == dlp_pkg::CH_NUL) begin
          if (phase_q == dlp_pkg::PH_START) begin
            clear       = 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = dlp_pkg::KIND_END;
          end else begin
            bad = 1'b1;
          end
        end else if (byte_i == dlp_pkg::CH_SPACE) begin
          if (name_seen_q == '0) begin
            bad = 1'b1;
          end else begin
            phase_d = dlp_pkg::PH_COUNT;
          end
        end else if (byte_i == dlp_pkg::CH_NL || {1'b0, name_seen_q} >= limit) begin
          bad = 1'b1;
        end else begin
          name_seen_d     = name_seen_q + 6'd1;
          phase_d         = dlp_pkg::PH_NAME;
          res_valid_o     = 1'b1;
          res_o.kind      = dlp_pkg::KIND_NAME;
          res_o.name_char = byte_i;
        end
      end
      dlp_pkg::PH_COUNT: begin
        if (byte_i inside {[dlp_pkg::CH_ZERO:dlp_pkg::CH_NINE]}) begin
          if (digits_seen_q >= dlp_pkg::MAX_COUNT_DIGITS) begin
            bad = 1'b1;
          end else begin
            // Times ten as two shifted adds, kept to 60 bits.
            count_acc_d   = {count_acc_q[56:0], 3'b000} + {count_acc_q[58:0], 1'b0}
                          + dlp_pkg::CountWidth'(digit);
            digits_seen_d = digits_seen_q + 5'd1;
          end
        end else if (byte_i == dlp_pkg::CH_SPACE && digits_seen_q != '0) begin
          phase_d = dlp_pkg::PH_HASH;
        end else begin
          bad = 1'b1;
        end
      end
      dlp_pkg::PH_HASH: begin
        if (byte_i == dlp_pkg::CH_NL) begin
          if (hash_seen_q != dlp_pkg::HASH_BYTES) begin
            bad = 1'b1;
          end else begin
            res_valid_o       = 1'b1;
            res_o.kind        = dlp_pkg::KIND_ROW;
            res_o.name_length = name_seen_q;
            res_o.row_count   = count_acc_q;
            res_o.hash_high   = hash_hi_q;
            res_o.hash_low    = hash_lo_q;
            clear             = 1'b1;
            phase_d           = dlp_pkg::PH_START;
          end
        end else if (byte_i == dlp_pkg::CH_NUL || hash_seen_q >= dlp_pkg::HASH_BYTES) begin
          bad = 1'b1;
        end else begin
          if (hash_seen_q < dlp_pkg::HASH_HALF) begin
            hash_hi_d = {hash_hi_q[55:0], byte_i};
          end else begin
            hash_lo_d = {hash_lo_q[55:0], byte_i};
          end
          hash_seen_d = hash_seen_q + 5'd1;
        end
      end
      default: begin
        // Skip after a bad line until the end of the buffer.
        if (byte_i == dlp_pkg::CH_NUL) begin
          clear   = 1'b1;
          phase_d = dlp_pkg::PH_START;
        end
      end
    endcase

    // A bad line reports once and then skips, unless the zero byte ended it.
    if (bad) begin
      clear       = 1'b1;
      phase_d     = (byte_i == dlp_pkg::CH_NUL) ? dlp_pkg::PH_START : dlp_pkg::PH_SKIP;
      res_valid_o = 1'b1;
      res_o       = '0;
      res_o.kind  = dlp_pkg::KIND_BAD;
    end

    if (clear) begin
      name_seen_d   = '0;
      count_acc_d   = '0;
      digits_seen_d = '0;
      hash_hi_d     = '0;
      hash_lo_d     = '0;
      hash_seen_d   = '0;
    end
  end

  // Line state registers, updated once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= dlp_pkg::PH_START;
      name_seen_q   <= '0;
      count_acc_q   <= '0;
      digits_seen_q <= '0;
      hash_hi_q     <= '0;
      hash_lo_q     <= '0;
      hash_seen_q   <= '0;
    end else if (advance_i) begin
      phase_q       <= phase_d;
      name_seen_q   <= name_seen_d;
      count_acc_q   <= count_acc_d;
      digits_seen_q <= digits_seen_d;
      hash_hi_q     <= hash_hi_d;
      hash_lo_q     <= hash_lo_d;
      hash_seen_q   <= hash_seen_d;
    end
  end

`ifndef SYNTHESIS
  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == dlp_pkg::PH_START || phase_q == dlp_pkg::PH_SKIP) |->
      (name_seen_q == '0 && digits_seen_q == '0 && hash_seen_q == '0))
    else $error("line counters not cleared at line start or skip");
  a_count_has_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == dlp_pkg::PH_COUNT || phase_q == dlp_pkg::PH_HASH) |-> name_seen_q != '0)
    else $error("count or hash phase reached with an empty name");
  a_hash_has_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == dlp_pkg::PH_HASH) |-> digits_seen_q != '0)
    else $error("hash phase reached with an empty count");
  a_digit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_seen_q <= dlp_pkg::MAX_COUNT_DIGITS)
    else $error("count digit counter past its limit");
  a_hash_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_seen_q <= dlp_pkg::HASH_BYTES)
    else $error("hash byte counter past its limit");
`endif

endmodule

// ===== rtl/core/dlp_out_reg.sv =====
module dlp_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  dlp_pkg::res_t res_i,
  output logic          ready_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dlp_pkg::res_t res_o
);

  logic          valid_q;
  dlp_pkg::res_t res_q;

  // The register loads whenever it is empty or its request is being taken.
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/core/digest_line_parser.sv =====
// A byte accepted into the input register is parsed from there, and its result is registered in the result register.
// Throughput: one byte per cycle while the receiver does not stall; the line state updates once per byte.
// A result held by a stalled receiver keeps the next byte waiting in the input register.
// Bytes that cause no result (separators, count digits, hash bytes) yield no request.
// Reset is asynchronous and active low: line state returns to line start with all
// counters and the hash cleared, and name_capacity returns to 40.
module digest_line_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dlp_pkg::CapWidth-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      in_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      kind_o,
  output logic [7:0]                      name_char_o,
  output logic [dlp_pkg::NameWidth-1:0]   name_length_o,
  output logic [dlp_pkg::CountWidth-1:0]  row_count_o,
  output logic [dlp_pkg::HashWidth-1:0]   hash_high_o,
  output logic [dlp_pkg::HashWidth-1:0]   hash_low_o
);

  logic          ready;
  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          advance;
  logic          res_valid;
  dlp_pkg::res_t res;
  dlp_pkg::res_t out_res;

  // Input register stage.
  dlp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .ready_i    (ready),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  // The held byte is parsed when the result register can take its outcome.
  assign advance = s1_valid && ready;

  dlp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .byte_i      (s1_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register stage.
  dlp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid && res_valid),
    .res_i       (res),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign kind_o        = out_res.kind;
  assign name_char_o   = out_res.name_char;
  assign name_length_o = out_res.name_length;
  assign row_count_o   = out_res.row_count;
  assign hash_high_o   = out_res.hash_high;
  assign hash_low_o    = out_res.hash_low;

endmodule

// ===== test/tb_digest_line_parser.sv =====
module tb_digest_line_parser;
  import dlp_pkg::*;

  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_BYTES    = 50;
  localparam int NUM_FAULTS     = 10;

  // Ways a line can be malformed.
  typedef enum int {
    FAULT_EMPTY_NAME,
    FAULT_LONG_NAME,
    FAULT_NAME_NL,
    FAULT_NAME_NUL,
    FAULT_EMPTY_COUNT,
    FAULT_COUNT_CHAR,
    FAULT_COUNT_DIGITS,
    FAULT_SHORT_HASH,
    FAULT_LONG_HASH,
    FAULT_HASH_NUL
  } line_fault_e;

  // Tracks the parser state and holds the reports each accepted byte should produce.
  class line_result_tracker;
    logic [CapWidth-1:0]   capacity;
    logic [2:0]            phase;
    int                    name_seen;
    logic [CountWidth-1:0] count;
    int                    digits;
    logic [HashWidth-1:0]  hash_hi;
    logic [HashWidth-1:0]  hash_lo;
    int                    hash_seen;
    int                    failures;
    res_t                  pending_reports[$];

    function new();
      capacity = CAP_RESET;
      phase = PH_START;
      failures = 0;
      clear_line();
    endfunction

    function void clear_line();
      name_seen = 0;
      count = '0;
      digits = 0;
      hash_hi = '0;
      hash_lo = '0;
      hash_seen = 0;
    endfunction

    // Longest name the current capacity allows, capped by the name length width.
    function int name_limit();
      int lim;
      lim = (capacity == '0) ? 0 : int'(capacity) - 1;
      return (lim > int'(NAME_MAX_BYTES)) ? int'(NAME_MAX_BYTES) : lim;
    endfunction

    // A fault drops the line; a zero byte also ends the skip right away.
    function bit line_bad(input logic [7:0] b, output res_t r);
      clear_line();
      phase = (b == CH_NUL) ? PH_START : PH_SKIP;
      r = '0;
      r.kind = KIND_BAD;
      return 1'b1;
    endfunction

    // Advances the line state by one byte; returns 1 when a report is due.
    function bit parse_byte(input logic [7:0] b, output res_t r);
      int lim;
      lim = name_limit();
      r = '0;
      case (phase)
        PH_START, PH_NAME: begin
          if (b == CH_NUL) begin
            if (phase == PH_START) begin
              clear_line();
              r.kind = KIND_END;
              return 1'b1;
            end
            return line_bad(b, r);
          end
          if (b == CH_SPACE) begin
            if (name_seen == 0) return line_bad(b, r);
            phase = PH_COUNT;
            return 1'b0;
          end
          if (b == CH_NL || name_seen >= lim) return line_bad(b, r);
          name_seen++;
          phase = PH_NAME;
          r.kind = KIND_NAME;
          r.name_char = b;
          return 1'b1;
        end
        PH_COUNT: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            if (digits >= int'(MAX_COUNT_DIGITS)) return line_bad(b, r);
            count = count * 60'd10 + 60'(b - CH_ZERO);
            digits++;
            return 1'b0;
          end
          if (b == CH_SPACE && digits != 0) begin
            phase = PH_HASH;
            return 1'b0;
          end
          return line_bad(b, r);
        end
        PH_HASH: begin
          if (b == CH_NL) begin
            if (hash_seen != int'(HASH_BYTES)) return line_bad(b, r);
            r.kind = KIND_ROW;
            r.name_length = name_seen[NameWidth-1:0];
            r.row_count = count;
            r.hash_high = hash_hi;
            r.hash_low = hash_lo;
            clear_line();
            phase = PH_START;
            return 1'b1;
          end
          if (b == CH_NUL || hash_seen >= int'(HASH_BYTES)) return line_bad(b, r);
          if (hash_seen < int'(HASH_HALF)) begin
            hash_hi = {hash_hi[HashWidth-9:0], b};
          end else begin
            hash_lo = {hash_lo[HashWidth-9:0], b};
          end
          hash_seen++;
          return 1'b0;
        end
        default: begin
          if (b == CH_NUL) begin
            clear_line();
            phase = PH_START;
          end
        end
      endcase
      return 1'b0;
    endfunction

    function void note_byte(logic [7:0] b);
      res_t r;
      if (parse_byte(b, r)) pending_reports.push_back(r);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 'h%0h, got 'h%0h", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_reports.size() == 0) begin
        $error("kind %0d reported with no request outstanding", got.kind);
        failures++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("kind", 64'(want.kind), 64'(got.kind));
      compare_field("name_char", 64'(want.name_char), 64'(got.name_char));
      compare_field("name_length", 64'(want.name_length), 64'(got.name_length));
      compare_field("row_count", 64'(want.row_count), 64'(got.row_count));
      compare_field("hash_high", want.hash_high, got.hash_high);
      compare_field("hash_low", want.hash_low, got.hash_low);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CapWidth-1:0]   cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            in_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [1:0]            kind_o;
  logic [7:0]            name_char_o;
  logic [NameWidth-1:0]  name_length_o;
  logic [CountWidth-1:0] row_count_o;
  logic [HashWidth-1:0]  hash_high_o;
  logic [HashWidth-1:0]  hash_low_o;

  line_result_tracker tracker;
  logic [7:0]         tx_bytes[$];
  bit                 quiet = 1'b0;
  bit                 long_hold_req = 1'b0;
  int                 bytes_sent = 0;
  int                 idle_cycles = 0;

  digest_line_parser u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .name_char_o  (name_char_o),
    .name_length_o(name_length_o),
    .row_count_o  (row_count_o),
    .hash_high_o  (hash_high_o),
    .hash_low_o   (hash_low_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A nonzero byte that is never a newline, and optionally never a space.
  function automatic logic [7:0] random_byte(bit no_space);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (b == CH_NL || (no_space && b == CH_SPACE));
    return b;
  endfunction

  function automatic void push_name(int n);
    repeat (n) tx_bytes.push_back(random_byte(1'b1));
  endfunction

  function automatic void push_digits(int n);
    repeat (n) tx_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void push_hash(int n);
    repeat (n) tx_bytes.push_back(random_byte(1'b0));
  endfunction

  function automatic int pick_digits();
    return ($urandom_range(0, 4) == 0) ? int'(MAX_COUNT_DIGITS)
                                       : $urandom_range(1, int'(MAX_COUNT_DIGITS));
  endfunction

  // Short names most of the time, the longest allowed name now and then.
  function automatic int pick_name_len();
    int lim;
    lim = tracker.name_limit();
    if (lim < 1) return 1;
    if ($urandom_range(0, 9) == 0) return lim;
    return $urandom_range(1, (lim < 8) ? lim : 8);
  endfunction

  function automatic void push_good_line(int name_len);
    push_name(name_len);
    tx_bytes.push_back(CH_SPACE);
    push_digits(pick_digits());
    tx_bytes.push_back(CH_SPACE);
    push_hash(int'(HASH_BYTES));
    tx_bytes.push_back(CH_NL);
  endfunction

  // Bytes after a bad line, closed by a zero; the parser skips them unless a zero already ended the line.
  function automatic void push_skip_tail();
    repeat ($urandom_range(0, 4)) tx_bytes.push_back(8'($urandom_range(1, 255)));
    tx_bytes.push_back(CH_NUL);
  endfunction

  function automatic void push_broken_line(line_fault_e fault);
    logic [7:0] b;
    case (fault)
      FAULT_EMPTY_NAME: tx_bytes.push_back(CH_SPACE);
      FAULT_LONG_NAME: push_name(tracker.name_limit() + 1);
      FAULT_NAME_NL: begin
        push_name($urandom_range(0, 3));
        tx_bytes.push_back(CH_NL);
      end
      FAULT_NAME_NUL: begin
        push_name($urandom_range(1, 3));
        tx_bytes.push_back(CH_NUL);
      end
      FAULT_EMPTY_COUNT: begin
        push_name($urandom_range(1, 3));
        tx_bytes.push_back(CH_SPACE);
        tx_bytes.push_back(CH_SPACE);
      end
      FAULT_COUNT_CHAR: begin
        push_name($urandom_range(1, 3));
        tx_bytes.push_back(CH_SPACE);
        push_digits($urandom_range(0, 3));
        do begin
          b = 8'($urandom_range(0, 255));
        end while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SPACE);
        tx_bytes.push_back(b);
      end
      FAULT_COUNT_DIGITS: begin
        push_name($urandom_range(1, 3));
        tx_bytes.push_back(CH_SPACE);
        push_digits(int'(MAX_COUNT_DIGITS) + 1);
      end
      FAULT_SHORT_HASH: begin
        push_name($urandom_range(1, 3));
        tx_bytes.push_back(CH_SPACE);
        push_digits(pick_digits());
        tx_bytes.push_back(CH_SPACE);
        push_hash($urandom_range(0, int'(HASH_BYTES) - 1));
        tx_bytes.push_back(CH_NL);
      end
      FAULT_LONG_HASH: begin
        push_name($urandom_range(1, 3));
        tx_bytes.push_back(CH_SPACE);
        push_digits(pick_digits());
        tx_bytes.push_back(CH_SPACE);
        push_hash(int'(HASH_BYTES) + 1);
      end
      FAULT_HASH_NUL: begin
        push_name($urandom_range(1, 3));
        tx_bytes.push_back(CH_SPACE);
        push_digits(pick_digits());
        tx_bytes.push_back(CH_SPACE);
        push_hash($urandom_range(0, int'(HASH_BYTES) - 1));
        tx_bytes.push_back(CH_NUL);
      end
    endcase
    push_skip_tail();
  endfunction

  // One byte request; valid stays high when the next byte follows without a gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_queue();
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
  endtask

  // Waits for every outstanding report, then lets in-flight bytes settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapWidth-1:0] cap);
    wait_drained();
    cfg_wdata_i <= cap;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.capacity = cap;
  endtask

  // Mostly well-formed lines with random content, plus broken lines and noise.
  task automatic run_phase(input int n_bytes);
    int start;
    int r;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        push_good_line(pick_name_len());
      end else if (r < 85) begin
        push_broken_line(line_fault_e'($urandom_range(0, NUM_FAULTS - 1)));
      end else if (r < 93) begin
        tx_bytes.push_back(CH_NUL);
      end else begin
        repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_queue();
    end
  endtask

  // Result side: check each accepted report and stall at random.
  initial begin : receiver
    int   hold_left;
    res_t got;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.kind        = kind_o;
        got.name_char   = name_char_o;
        got.name_length = name_length_o;
        got.row_count   = row_count_o;
        got.hash_high   = hash_high_o;
        got.hash_low    = hash_low_o;
        tracker.check_result(got);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
        hold_left = pick_gap();
      end
    end
  end

  // Ends the run if no request moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("digest_line_parser test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [CapWidth-1:0] caps[7];
    tracker = new();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= CAP_RESET;
    in_valid_i  <= 1'b0;
    in_byte_i   <= 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // End of reply on an empty line.
    tx_bytes.push_back(CH_NUL);
    // Extreme name bytes, the largest count and an all-ones hash.
    tx_bytes.push_back(8'h01);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'h7F);
    tx_bytes.push_back(CH_SPACE);
    repeat (int'(MAX_COUNT_DIGITS)) tx_bytes.push_back(CH_NINE);
    tx_bytes.push_back(CH_SPACE);
    repeat (int'(HASH_BYTES)) tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(CH_NL);
    // Longest name, a zero count and a hash of low bytes that includes spaces.
    push_name(tracker.name_limit());
    tx_bytes.push_back(CH_SPACE);
    tx_bytes.push_back(CH_ZERO);
    tx_bytes.push_back(CH_SPACE);
    tx_bytes.push_back(8'h01);
    for (int i = 0; i < int'(HASH_BYTES) - 1; i++) tx_bytes.push_back(CH_SPACE + 8'(i));
    tx_bytes.push_back(CH_NL);
    // A newline on an empty line, then every kind of malformed line.
    tx_bytes.push_back(CH_NL);
    tx_bytes.push_back(CH_NUL);
    for (int f = 0; f < NUM_FAULTS; f++) push_broken_line(line_fault_e'(f));
    tx_bytes.push_back(CH_NUL);
    send_queue();

    // Random phases over a range of name capacities, including the odd ones.
    caps[0] = 7'd2;
    caps[1] = 7'd64;
    caps[2] = 7'd127;
    caps[3] = 7'd0;
    caps[4] = 7'd1;
    caps[5] = 7'($urandom_range(3, 63));
    caps[6] = CAP_RESET;
    for (int i = 0; i < 7; i++) begin
      write_capacity(caps[i]);
      quiet = (i == 2);
      // The receiver holds off while lines keep coming, so the parser backs up.
      if (i == 1) long_hold_req = 1'b1;
      run_phase(PHASE_BYTES);
    end
    quiet = 1'b0;

    wait_drained();
    if (tracker.failures == 0) begin
      $display("digest_line_parser test passed");
    end else begin
      $display("digest_line_parser test failed");
    end
    $finish;
  end

endmodule
